[rtl/mtfs_pkg.sv]
// ----------------------------------------------------------------------------
// mtfs_pkg
// Shared types and constants for the motor and temperature fault supervisor:
// configuration register indexes, reset values, command and reason codes,
// and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package mtfs_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_VOLTAGE_MV  = 3'd0,
        REG_MOTOR_WAIT_MS   = 3'd1,
        REG_MOTOR_SPINUP_MS = 3'd2,
        REG_MOTOR_EXIT_MS   = 3'd3,
        REG_TEMP_WAIT_MS    = 3'd4,
        REG_TEMP_SLOPE_Q16  = 3'd5,
        REG_TEMP_OFFSET     = 3'd6
    } t_reg_idx;

    // Register reset values.
    localparam logic [14:0] RST_LOW_VOLTAGE_MV  = 15'd10500;
    localparam logic [15:0] RST_MOTOR_WAIT_MS   = 16'd250;
    localparam logic [15:0] RST_MOTOR_SPINUP_MS = 16'd250;
    localparam logic [15:0] RST_MOTOR_EXIT_MS   = 16'd1000;
    localparam logic [15:0] RST_TEMP_WAIT_MS    = 16'd30000;
    localparam logic [15:0] RST_TEMP_SLOPE_Q16  = 16'd3121;
    localparam logic [11:0] RST_TEMP_OFFSET     = 12'd95;

    // Command codes carried by an input transaction.
    localparam logic CMD_EVAL   = 1'b0;
    localparam logic CMD_REINIT = 1'b1;

    // Fault reason codes.
    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_MOTOR = 2'd1;
    localparam logic [1:0] REASON_TEMP  = 2'd2;

    // Full configuration register set.
    typedef struct packed {
        logic [14:0] low_voltage_mv;
        logic [15:0] motor_wait_ms;
        logic [15:0] motor_spinup_ms;
        logic [15:0] motor_exit_ms;
        logic [15:0] temp_wait_ms;
        logic [15:0] temp_slope_q16;
        logic [11:0] temp_offset;
    } t_cfg;

    // Item held in the input stage, with the scaled supply voltage.
    typedef struct packed {
        logic        cmd;
        logic [15:0] elapsed_ms;
        logic        system_running;
        logic [14:0] supply_mv;
        logic [11:0] temperature_adc;
        logic [14:0] scaled_mv;
    } t_stage_item;

    // Handshake between the input stage and the core.
    typedef struct packed {
        logic        valid;
        t_stage_item item;
    } t_stage_bus;

endpackage

[rtl/mtfs_if.sv]
// ----------------------------------------------------------------------------
// mtfs_if
// Channel interfaces of the supervisor: input items, results and
// configuration writes, each a valid/ready channel.
// ----------------------------------------------------------------------------
interface mtfs_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] elapsed_ms;
    logic        system_running;
    logic [14:0] supply_mv;
    logic [11:0] temperature_adc;

    modport source (output valid, cmd, elapsed_ms, system_running, supply_mv,
                    temperature_adc, input ready);
    modport sink   (input valid, cmd, elapsed_ms, system_running, supply_mv,
                    temperature_adc, output ready);
endinterface

interface mtfs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  motor_fsm;
    logic [1:0]  temp_fsm;
    logic        retry_pulse;
    logic        error_entered;
    logic        fault_latched;
    logic [1:0]  fault_reason;
    logic [15:0] temp_threshold;

    modport source (output valid, motor_fsm, temp_fsm, retry_pulse, error_entered,
                    fault_latched, fault_reason, temp_threshold, input ready);
    modport sink   (input valid, motor_fsm, temp_fsm, retry_pulse, error_entered,
                    fault_latched, fault_reason, temp_threshold, output ready);
endinterface

interface mtfs_cfg_if;
    import mtfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mtfs_cfg.sv]
// ----------------------------------------------------------------------------
// mtfs_cfg
// Configuration register file. Always ready; a write to an index outside
// the register list is accepted and ignored.
// ----------------------------------------------------------------------------
module mtfs_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mtfs_cfg_if.sink       i_cfg,
    output mtfs_pkg::t_cfg o_cfg
);
    import mtfs_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes, each field truncated to its width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_voltage_mv  <= RST_LOW_VOLTAGE_MV;
            r_cfg.motor_wait_ms   <= RST_MOTOR_WAIT_MS;
            r_cfg.motor_spinup_ms <= RST_MOTOR_SPINUP_MS;
            r_cfg.motor_exit_ms   <= RST_MOTOR_EXIT_MS;
            r_cfg.temp_wait_ms    <= RST_TEMP_WAIT_MS;
            r_cfg.temp_slope_q16  <= RST_TEMP_SLOPE_Q16;
            r_cfg.temp_offset     <= RST_TEMP_OFFSET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LOW_VOLTAGE_MV:  r_cfg.low_voltage_mv  <= i_cfg.data[14:0];
                REG_MOTOR_WAIT_MS:   r_cfg.motor_wait_ms   <= i_cfg.data;
                REG_MOTOR_SPINUP_MS: r_cfg.motor_spinup_ms <= i_cfg.data;
                REG_MOTOR_EXIT_MS:   r_cfg.motor_exit_ms   <= i_cfg.data;
                REG_TEMP_WAIT_MS:    r_cfg.temp_wait_ms    <= i_cfg.data;
                REG_TEMP_SLOPE_Q16:  r_cfg.temp_slope_q16  <= i_cfg.data;
                REG_TEMP_OFFSET:     r_cfg.temp_offset     <= i_cfg.data[11:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/mtfs_scale.sv]
// ----------------------------------------------------------------------------
// mtfs_scale
// Input stage. Registers the accepted item together with the supply voltage
// scaled by the threshold slope (Q0.16 multiply, integer part kept).
// ----------------------------------------------------------------------------
module mtfs_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mtfs_in_if.sink              i_item,
    input  logic [15:0]          i_slope_q16,
    input  logic                 i_next_ready,
    output mtfs_pkg::t_stage_bus o_stage
);
    import mtfs_pkg::*;

    logic        r_valid;
    t_stage_item r_item;
    logic        w_ready;
    logic [30:0] w_product;

    // The stage frees up when it is empty or its item moves on.
    assign w_ready      = !r_valid || i_next_ready;
    assign i_item.ready = w_ready;

    // Supply voltage times slope; only the integer part is kept.
    assign w_product = 31'(i_item.supply_mv) * 31'(i_slope_q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_ready && i_item.valid) begin
            r_item.cmd             <= i_item.cmd;
            r_item.elapsed_ms      <= i_item.elapsed_ms;
            r_item.system_running  <= i_item.system_running;
            r_item.supply_mv       <= i_item.supply_mv;
            r_item.temperature_adc <= i_item.temperature_adc;
            r_item.scaled_mv       <= w_product[30:16];
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

[rtl/mtfs_core.sv]
// ----------------------------------------------------------------------------
// mtfs_core
// Supervision core. Works out the overtemperature threshold, counts the
// timers down, steps the motor and temperature machines, latches the first
// fault and loads the result register.
// ----------------------------------------------------------------------------
module mtfs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mtfs_pkg::t_cfg       i_cfg,
    input  mtfs_pkg::t_stage_bus i_stage,
    output logic                 o_stage_ready,
    mtfs_out_if.source           o_result
);
    import mtfs_pkg::*;

    typedef enum logic [2:0] {
        M_OK   = 3'd0,
        M_WAIT = 3'd1,
        M_SPIN = 3'd2,
        M_ERR  = 3'd3,
        M_EXIT = 3'd4
    } t_motor_mode;

    typedef enum logic [1:0] {
        T_OK   = 2'd0,
        T_WAIT = 2'd1,
        T_ERR  = 2'd2
    } t_temp_mode;

    // Machine state.
    t_motor_mode r_motor_mode, n_motor_mode;
    t_motor_mode r_motor_ret, n_motor_ret;
    logic [15:0] r_motor_cnt, n_motor_cnt;
    logic        r_motor_armed, n_motor_armed;
    t_temp_mode  r_temp_mode, n_temp_mode;
    logic [15:0] r_temp_cnt, n_temp_cnt;
    logic        r_temp_armed, n_temp_armed;
    logic        r_latched, n_latched;
    logic [1:0]  r_reason, n_reason;

    // Result register.
    logic        r_out_valid;
    logic [2:0]  r_out_motor;
    logic [1:0]  r_out_temp;
    logic        r_out_pulse, n_pulse;
    logic        r_out_fired, n_fired;
    logic        r_out_latched;
    logic [1:0]  r_out_reason;
    logic [15:0] r_out_thr;

    logic        w_advance;
    logic [15:0] w_dt;
    logic [15:0] w_motor_dec;
    logic [15:0] w_temp_dec;
    logic [15:0] w_thr;
    logic        w_under;
    logic        w_hot;
    logic        w_m_exp;
    logic        w_t_exp;

    assign o_stage_ready = !r_out_valid || o_result.ready;
    assign w_advance     = i_stage.valid && o_stage_ready;
    assign w_dt          = i_stage.item.elapsed_ms;

    // Threshold: scaled voltage less the offset, floored at zero.
    always_comb begin
        if (i_stage.item.scaled_mv > 15'(i_cfg.temp_offset)) begin
            w_thr = 16'(i_stage.item.scaled_mv - 15'(i_cfg.temp_offset));
        end else begin
            w_thr = '0;
        end
    end

    assign w_under = i_stage.item.supply_mv < i_cfg.low_voltage_mv;
    assign w_hot   = 16'(i_stage.item.temperature_adc) > w_thr;

    // Armed timers count down, saturating at zero.
    assign w_motor_dec = !r_motor_armed ? r_motor_cnt :
                         (r_motor_cnt > w_dt) ? r_motor_cnt - w_dt : '0;
    assign w_temp_dec  = !r_temp_armed ? r_temp_cnt :
                         (r_temp_cnt > w_dt) ? r_temp_cnt - w_dt : '0;
    assign w_m_exp     = r_motor_armed && (w_motor_dec == '0);
    assign w_t_exp     = r_temp_armed && (w_temp_dec == '0);

    // Next state of both machines for the item in the input stage.
    always_comb begin
        n_motor_mode  = r_motor_mode;
        n_motor_ret   = r_motor_ret;
        n_motor_cnt   = w_motor_dec;
        n_motor_armed = r_motor_armed;
        n_temp_mode   = r_temp_mode;
        n_temp_cnt    = w_temp_dec;
        n_temp_armed  = r_temp_armed;
        n_latched     = r_latched;
        n_reason      = r_reason;
        n_pulse       = 1'b0;
        n_fired       = 1'b0;

        if (i_stage.item.cmd == CMD_REINIT) begin
            n_motor_mode  = M_OK;
            n_motor_ret   = M_OK;
            n_motor_cnt   = '0;
            n_motor_armed = 1'b0;
            n_temp_mode   = T_OK;
            n_temp_cnt    = '0;
            n_temp_armed  = 1'b0;
            n_latched     = 1'b0;
            n_reason      = REASON_NONE;
        end else if (i_stage.item.system_running && !r_latched) begin
            // Motor undervoltage machine.
            case (r_motor_mode)
                M_OK: begin
                    if (w_under) begin
                        n_motor_mode  = M_WAIT;
                        n_motor_cnt   = i_cfg.motor_wait_ms;
                        n_motor_armed = 1'b1;
                    end
                end
                M_WAIT, M_SPIN: begin
                    if (w_m_exp) begin
                        if (w_under && (r_motor_mode == M_WAIT)) begin
                            n_pulse       = 1'b1;
                            n_motor_mode  = M_SPIN;
                            n_motor_cnt   = i_cfg.motor_spinup_ms;
                            n_motor_armed = 1'b1;
                        end else if (w_under) begin
                            n_motor_mode = M_ERR;
                        end else begin
                            n_motor_ret   = r_motor_mode;
                            n_motor_mode  = M_EXIT;
                            n_motor_cnt   = i_cfg.motor_exit_ms;
                            n_motor_armed = 1'b1;
                        end
                    end
                end
                M_ERR: begin
                    n_fired   = 1'b1;
                    n_latched = 1'b1;
                    n_reason  = REASON_MOTOR;
                end
                M_EXIT: begin
                    if (w_m_exp) begin
                        if (w_under) begin
                            n_motor_mode  = r_motor_ret;
                            n_motor_cnt   = i_cfg.motor_exit_ms;
                            n_motor_armed = 1'b1;
                        end else begin
                            n_motor_mode = M_OK;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Temperature machine; its error overrides the motor reason.
            case (r_temp_mode)
                T_OK: begin
                    if (w_hot) begin
                        n_temp_mode  = T_WAIT;
                        n_temp_cnt   = i_cfg.temp_wait_ms;
                        n_temp_armed = 1'b1;
                    end
                end
                T_WAIT: begin
                    if (w_t_exp) begin
                        n_temp_mode = w_hot ? T_ERR : T_OK;
                    end
                end
                T_ERR: begin
                    n_fired   = 1'b1;
                    n_latched = 1'b1;
                    n_reason  = REASON_TEMP;
                end
                default: begin
                end
            endcase
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_mode  <= M_OK;
            r_motor_ret   <= M_OK;
            r_motor_cnt   <= '0;
            r_motor_armed <= 1'b0;
            r_temp_mode   <= T_OK;
            r_temp_cnt    <= '0;
            r_temp_armed  <= 1'b0;
            r_latched     <= 1'b0;
            r_reason      <= REASON_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_motor_mode  <= n_motor_mode;
                r_motor_ret   <= n_motor_ret;
                r_motor_cnt   <= n_motor_cnt;
                r_motor_armed <= n_motor_armed;
                r_temp_mode   <= n_temp_mode;
                r_temp_cnt    <= n_temp_cnt;
                r_temp_armed  <= n_temp_armed;
                r_latched     <= n_latched;
                r_reason      <= n_reason;
                r_out_valid   <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_motor   <= n_motor_mode;
            r_out_temp    <= n_temp_mode;
            r_out_pulse   <= n_pulse;
            r_out_fired   <= n_fired;
            r_out_latched <= n_latched;
            r_out_reason  <= n_reason;
            r_out_thr     <= w_thr;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.motor_fsm      = r_out_motor;
    assign o_result.temp_fsm       = r_out_temp;
    assign o_result.retry_pulse    = r_out_pulse;
    assign o_result.error_entered  = r_out_fired;
    assign o_result.fault_latched  = r_out_latched;
    assign o_result.fault_reason   = r_out_reason;
    assign o_result.temp_threshold = r_out_thr;

endmodule

[rtl/motor_temp_fault_supervisor_top.sv]
// ----------------------------------------------------------------------------
// motor_temp_fault_supervisor_top
// Motor undervoltage and overtemperature fault supervisor, one tick per
// input transaction and one result transaction per tick.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one supervision tick (evaluate or reinit command, elapsed
//   milliseconds, running flag, supply millivolts, temperature ADC value).
//   o_result returns the machine states, the retry and error-entry strobes,
//   the sticky fault flag and reason, and the threshold used for the tick.
//   i_cfg writes the seven configuration registers by index; it is always
//   ready and should be used only while no tick is in flight.
// Pipeline and throughput:
//   The input stage registers the item and the slope product, then the core
//   registers the updated state and the result. One tick is taken every
//   cycle while o_result accepts results.
// Reset:
//   i_rst_n (synchronous, active low) returns the configuration registers
//   to their default values, clears both machines, the timers and the fault
//   latch, and empties the pipeline.
// Stalls:
//   While o_result is held, the result register keeps its transaction, the
//   input stage fills, and then i_item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module motor_temp_fault_supervisor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtfs_in_if.sink    i_item,
    mtfs_cfg_if.sink   i_cfg,
    mtfs_out_if.source o_result
);
    import mtfs_pkg::*;

    t_cfg       w_cfg;
    t_stage_bus w_stage;
    logic       w_stage_ready;

    // Configuration registers.
    mtfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Input stage with the threshold slope multiply.
    mtfs_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_slope_q16  (w_cfg.temp_slope_q16),
        .i_next_ready (w_stage_ready),
        .o_stage      (w_stage)
    );

    // State machines and result register.
    mtfs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_stage       (w_stage),
        .o_stage_ready (w_stage_ready),
        .o_result      (o_result)
    );

endmodule
